// ===== design/scmsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Seam finder package
// Shared constants and register address codes of the seam finder core.
// ----------------------------------------------------------------------------
package scmsf_pkg;

  localparam int unsigned PixW  = 24;
  localparam int unsigned CostW = 25;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned SizeW = 7;

  typedef enum logic [1:0] {
    RegDirection = 2'd0,
    RegWidth     = 2'd1,
    RegHeight    = 2'd2,
    RegNone      = 2'd3
  } reg_addr_e;

  function automatic logic [17:0] sq_diff(input logic [PixW-1:0] p, input logic [PixW-1:0] q);
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    a0 = (p[23:16] > q[23:16]) ? p[23:16] - q[23:16] : q[23:16] - p[23:16];
    a1 = (p[15:8] > q[15:8]) ? p[15:8] - q[15:8] : q[15:8] - p[15:8];
    a2 = (p[7:0] > q[7:0]) ? p[7:0] - q[7:0] : q[7:0] - p[7:0];
    s0 = 16'(a0) * 16'(a0);
    s1 = 16'(a1) * 16'(a1);
    s2 = 16'(a2) * 16'(a2);
    return 18'(s0) + 18'(s1) + 18'(s2);
  endfunction

endpackage : scmsf_pkg
`default_nettype wire

// ===== design/seam_carving_min_seam_finder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Seam finder core
// Minimum-energy seam search over a loaded RGB frame.
// ----------------------------------------------------------------------------
// Usage: pixels are written in row-major order, one item per cycle, by
// raising start_i while busy_o is low. The item that completes the frame
// (image_width * image_height pixels) makes the core busy. It then computes
// the dual-gradient energy of every pixel from four reads of the pixel store,
// after an address state, with a wait and a compute state for each read. The
// cost recurrence only writes the energy on the first line; on the others it
// reads and compares each neighbour inside the image, skips one outside it
// and then writes the cost. The minimum search scans the last line for its
// first least cost, backtracking reads one back pointer per line, and after
// a setup state the seam is sent one entry per cycle on seam_valid_o with
// last_o on the final entry. busy_o is low from the cycle that carries the
// final entry. The receiver cannot stall results.
// Configuration is by the APB port and must be written while idle. Reset
// clears the load count, the registers (direction 0, size 64 by 64) and the
// sequencer; no memory is cleared.
// ----------------------------------------------------------------------------
module seam_carving_min_seam_finder_core
  import scmsf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  output logic                   seam_valid_o,
  output logic [IdxW-1:0]        seam_position_o,
  output logic [IdxW-1:0]        seam_index_o,
  output logic [CostW-1:0]       seam_cost_o,
  output logic                   last_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DimW   = $clog2(MaxDim + 1);
  localparam int unsigned CrW    = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned CrDep  = 2 * MaxDim;
  localparam int unsigned CrAW   = CrW + 1;

  typedef enum logic [3:0] {
    StLoad, StEAddr, StEWait, StECalc, StCRead, StCWait, StCCalc,
    StMin, StBtRd, StBtWt, StOut
  } state_e;

  // Configuration.
  logic                 direction_q;
  logic [SizeW-1:0]     width_q, height_q;
  logic                 cfg_wr;
  reg_addr_e            cfg_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_addr = (paddr[1:0] == 2'd0 && paddr[3:2] != 2'd3) ? reg_addr_e'(paddr[3:2])
                                                               : RegNone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      width_q     <= SizeW'(64);
      height_q    <= SizeW'(64);
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        RegDirection: direction_q <= pwdata[0];
        RegWidth:     width_q     <= pwdata[SizeW-1:0];
        RegHeight:    height_q    <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_addr)
      RegDirection: prdata = {31'd0, direction_q};
      RegWidth:     prdata = {25'd0, width_q};
      RegHeight:    prdata = {25'd0, height_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Clamped sizes.
  logic [DimW-1:0] w, h, lines, span;
  always_comb begin
    if (width_q == '0) w = DimW'(1);
    else if (32'(width_q) > MAX_WIDTH) w = DimW'(MAX_WIDTH);
    else w = DimW'(width_q);
    if (height_q == '0) h = DimW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h = DimW'(MAX_HEIGHT);
    else h = DimW'(height_q);
    lines = direction_q ? w : h;
    span  = direction_q ? h : w;
  end

  // Memories.
  logic [PixW-1:0]  pix_mem [Depth];
  logic [CostW-1:0] cost_mem [CrDep];
  logic [1:0]       bp_mem [Depth];
  logic [IdxW-1:0]  seam_mem [MaxDim];

  logic             pix_we;
  logic [AddrW-1:0] pix_wa, pix_ra;
  logic [PixW-1:0]  pix_rd;
  logic             cost_we;
  logic [CrAW-1:0]  cost_wa, cost_ra;
  logic [CostW-1:0] cost_wd, cost_rd;
  logic             bp_we;
  logic [AddrW-1:0] bp_wa, bp_ra;
  logic [1:0]       bp_wd, bp_rd;
  logic             seam_we;
  logic [CrW-1:0]   seam_wa, seam_ra;
  logic [IdxW-1:0]  seam_wd, seam_rd;

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_wa] <= {red_i, green_i, blue_i};
    pix_rd <= pix_mem[pix_ra];
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_rd <= cost_mem[cost_ra];
    if (bp_we) bp_mem[bp_wa] <= bp_wd;
    bp_rd <= bp_mem[bp_ra];
    if (seam_we) seam_mem[seam_wa] <= seam_wd;
    seam_rd <= seam_mem[seam_ra];
  end

  // Sequencer.
  state_e           state_q;
  logic [12:0]      load_q;
  logic [DimW-1:0]  line_q, c_q;
  logic [2:0]       k_q;
  logic             cur_q;
  logic [PixW-1:0]  pa_q;
  logic [18:0]      eacc_q;
  logic [CostW-1:0] bval_q, best_q;
  logic             have_q;
  logic [1:0]       bcode_q;
  logic [DimW-1:0]  bc_q;
  logic [DimW-1:0]  out_q;

  logic [DimW-1:0] row, col, nb_r, nb_c;
  logic [DimW:0]   cand;
  logic            cand_ok;
  logic [12:0]     load_nx;
  logic [17:0]     sq_cur;

  assign busy_o  = (state_q != StLoad);
  assign load_nx = load_q + 13'd1;
  assign row     = direction_q ? c_q : line_q;
  assign col     = direction_q ? line_q : c_q;
  assign sq_cur  = sq_diff(pa_q, pix_rd);

  // Neighbour of the current pixel for energy read k (0..3, wrapped).
  always_comb begin
    nb_r = row;
    nb_c = col;
    unique case (k_q[1:0])
      2'd0: nb_c = (col + 1'b1 == w) ? '0 : col + 1'b1;
      2'd1: nb_c = (col == '0) ? w - 1'b1 : col - 1'b1;
      2'd2: nb_r = (row + 1'b1 == h) ? '0 : row + 1'b1;
      default: nb_r = (row == '0) ? h - 1'b1 : row - 1'b1;
    endcase
  end

  // Candidate k of the recurrence: first preferred, centre, last.
  always_comb begin
    unique case (k_q[1:0])
      2'd0: cand = direction_q ? {1'b0, c_q} + 1'b1 : {1'b0, c_q} - 1'b1;
      2'd1: cand = {1'b0, c_q};
      default: cand = direction_q ? {1'b0, c_q} - 1'b1 : {1'b0, c_q} + 1'b1;
    endcase
    cand_ok = !cand[DimW] && (cand[DimW-1:0] < span) && (k_q < 3'd3);
  end

  logic [AddrW-1:0] bp_idx;
  assign bp_idx = AddrW'(line_q) * AddrW'(span) + AddrW'(c_q);

  always_comb begin
    pix_we  = (state_q == StLoad) && start_i && (32'(load_q) < Depth);
    pix_wa  = AddrW'(load_q);
    pix_ra  = AddrW'(nb_r) * AddrW'(w) + AddrW'(nb_c);
    cost_ra = {~cur_q, cand[CrW-1:0]};
    cost_we = 1'b0;
    cost_wa = {cur_q, c_q[CrW-1:0]};
    cost_wd = (line_q == '0) ? CostW'(eacc_q) : CostW'(eacc_q) + bval_q;
    bp_we   = 1'b0;
    bp_wa   = bp_idx;
    bp_wd   = (line_q == '0) ? 2'd1 : bcode_q;
    bp_ra   = bp_idx;
    seam_we = (state_q == StBtWt);
    seam_wa = line_q[CrW-1:0];
    seam_wd = IdxW'(c_q);
    seam_ra = out_q[CrW-1:0];
    if (state_q == StCCalc) begin
      cost_we = 1'b1;
      bp_we   = 1'b1;
    end
    if (state_q == StMin) cost_ra = {~cur_q, c_q[CrW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StLoad;
      load_q          <= '0;
      line_q          <= '0;
      c_q             <= '0;
      k_q             <= '0;
      cur_q           <= 1'b0;
      out_q           <= '0;
      pa_q            <= '0;
      eacc_q          <= '0;
      bval_q          <= '0;
      best_q          <= '0;
      have_q          <= 1'b0;
      bcode_q         <= 2'd1;
      bc_q            <= '0;
      seam_valid_o    <= 1'b0;
      seam_position_o <= '0;
      seam_index_o    <= '0;
      seam_cost_o     <= '0;
      last_o          <= 1'b0;
    end else begin
      seam_valid_o <= 1'b0;
      unique case (state_q)
        StLoad: if (start_i) begin
          if (32'(load_nx) >= 32'(w) * 32'(h)) begin
            load_q  <= '0;
            line_q  <= '0;
            c_q     <= '0;
            k_q     <= '0;
            cur_q   <= 1'b0;
            state_q <= StEAddr;
          end else begin
            load_q <= load_nx;
          end
        end
        StEAddr: begin
          state_q <= StEWait;
        end
        StEWait: begin
          state_q <= StECalc;
        end
        StECalc: begin
          k_q <= k_q + 3'd1;
          if (k_q[0]) begin
            eacc_q <= (k_q == 3'd1) ? 19'(sq_cur) : eacc_q + 19'(sq_cur);
          end else begin
            pa_q <= pix_rd;
          end
          if (k_q == 3'd3) begin
            k_q     <= '0;
            have_q  <= 1'b0;
            bcode_q <= 2'd1;
            bval_q  <= '0;
            state_q <= (line_q == '0) ? StCCalc : StCRead;
          end else begin
            state_q <= StEWait;
          end
        end
        StCRead: begin
          if (cand_ok) state_q <= StCWait;
          else if (k_q >= 3'd2) state_q <= StCCalc;
          else k_q <= k_q + 3'd1;
        end
        StCWait: begin
          if (!have_q || cost_rd < bval_q) begin
            have_q  <= 1'b1;
            bval_q  <= cost_rd;
            bcode_q <= k_q[1:0];
          end
          if (k_q >= 3'd2) state_q <= StCCalc;
          else begin
            k_q     <= k_q + 3'd1;
            state_q <= StCRead;
          end
        end
        StCCalc: begin
          k_q <= '0;
          if (c_q + 1'b1 == span) begin
            c_q   <= '0;
            cur_q <= ~cur_q;
            if (line_q + 1'b1 == lines) begin
              state_q <= StMin;
              out_q   <= '0;
              have_q  <= 1'b0;
            end else begin
              line_q  <= line_q + 1'b1;
              state_q <= StEAddr;
            end
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= StEAddr;
          end
        end
        StMin: begin
          // c_q is the read address and the read data trails it; out_q[0] marks a held best.
          if (have_q && (!out_q[0] || cost_rd < best_q)) begin
            best_q <= cost_rd;
            bc_q   <= c_q - 1'b1;
          end
          out_q[0] <= 1'b1;
          have_q   <= 1'b1;
          if (have_q && c_q == span) begin
            c_q     <= bc_q;
            if (!(!out_q[0] || cost_rd < best_q)) c_q <= bc_q;
            else c_q <= c_q - 1'b1;
            line_q  <= lines - 1'b1;
            state_q <= StBtRd;
          end else if (c_q != span) begin
            c_q <= c_q + 1'b1;
          end
          if (!have_q) out_q[0] <= 1'b0;
        end
        StBtRd: begin
          state_q <= StBtWt;
        end
        StBtWt: begin
          unique case (bp_rd)
            2'd0: c_q <= direction_q ? ((c_q + 1'b1 == span) ? c_q : c_q + 1'b1)
                                     : ((c_q == '0) ? c_q : c_q - 1'b1);
            2'd2: c_q <= direction_q ? ((c_q == '0) ? c_q : c_q - 1'b1)
                                     : ((c_q + 1'b1 == span) ? c_q : c_q + 1'b1);
            default: ;
          endcase
          if (line_q == '0) begin
            out_q   <= '0;
            state_q <= StOut;
            k_q     <= '0;
          end else begin
            line_q  <= line_q - 1'b1;
            state_q <= StBtRd;
          end
        end
        StOut: begin
          if (k_q == '0) begin
            k_q   <= 3'd1;
            out_q <= out_q + 1'b1;
          end else begin
            seam_valid_o    <= 1'b1;
            seam_position_o <= IdxW'(out_q - 1'b1);
            seam_index_o    <= seam_rd;
            seam_cost_o     <= best_q;
            last_o          <= (out_q == lines);
            if (out_q == lines) state_q <= StLoad;
            else out_q <= out_q + 1'b1;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Seam results appear only while busy or with last_o; busy_o is low with the final entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seam_valid_o |-> busy_o || last_o)
    else $error("result outside search");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> !seam_valid_o || $past(state_q) == StOut)
    else $error("stray result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seam_valid_o && last_o |-> !busy_o)
    else $error("busy after last");

endmodule : seam_carving_min_seam_finder_core
`default_nettype wire

// ===== sim/seam_carving_min_seam_finder_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seam finder core testbench
// Loads RGB frames of many sizes in both seam directions, predicts each
// minimum-energy seam with its own dynamic program, and compares every seam
// entry from the core with the predicted one, field by field.
// ----------------------------------------------------------------------------
module seam_carving_min_seam_finder_core_tb;
  import scmsf_pkg::*;

  localparam int unsigned MaxDim     = 64;
  localparam int unsigned StoreDepth = MaxDim * MaxDim;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [IdxW-1:0]  pos;
    logic [IdxW-1:0]  idx;
    logic [CostW-1:0] cost;
    logic             last;
  } seam_entry_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [7:0]        red_i = '0;
  logic [7:0]        green_i = '0;
  logic [7:0]        blue_i = '0;
  logic              seam_valid_o;
  logic [IdxW-1:0]   seam_position_o;
  logic [IdxW-1:0]   seam_index_o;
  logic [CostW-1:0]  seam_cost_o;
  logic              last_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  seam_carving_min_seam_finder_core u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .red_i, .green_i, .blue_i,
    .seam_valid_o, .seam_position_o, .seam_index_o, .seam_cost_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  logic [PixW-1:0]  pix_mem [StoreDepth];
  int unsigned      cost_prev [MaxDim];
  int unsigned      cost_next [MaxDim];
  logic [1:0]       back_ptr [StoreDepth];
  int unsigned      load_cnt = 0;
  logic             cfg_dir = 1'b0;
  logic [SizeW-1:0] cfg_w = 7'd64;
  logic [SizeW-1:0] cfg_h = 7'd64;

  seam_entry_t      pending_seam_q [$];
  int unsigned      errors = 0;
  int unsigned      pixels_sent = 0;
  int unsigned      cycles = 0;
  bit               steady = 1'b0;

  function automatic int unsigned clamp_dim(logic [SizeW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic int unsigned colour_dist(logic [PixW-1:0] p, logic [PixW-1:0] q);
    int unsigned s;
    int d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(p[8*k +: 8]) - int'(q[8*k +: 8]);
      s += d * d;
    end
    return s;
  endfunction

  function automatic int unsigned pixel_energy(int unsigned r, int unsigned c,
                                               int unsigned w, int unsigned h);
    return colour_dist(pix_mem[r*w + (c+1)%w], pix_mem[r*w + (c+w-1)%w]) +
           colour_dist(pix_mem[((r+1)%h)*w + c], pix_mem[((r+h-1)%h)*w + c]);
  endfunction

  function automatic void predict_seam();
    int unsigned w, h, lines, span, e, bval, bcode, best, best_c, c;
    int cand, nc, s;
    bit have;
    seam_entry_t ent;
    int unsigned path [MaxDim];
    w = clamp_dim(cfg_w);
    h = clamp_dim(cfg_h);
    lines = cfg_dir ? w : h;
    span = cfg_dir ? h : w;
    s = cfg_dir ? 1 : -1;
    for (int unsigned ln = 0; ln < lines; ln++) begin
      for (int unsigned x = 0; x < span; x++) begin
        e = cfg_dir ? pixel_energy(x, ln, w, h) : pixel_energy(ln, x, w, h);
        if (ln == 0) begin
          cost_next[x] = e;
          back_ptr[x] = 2'd1;
        end else begin
          have = 1'b0;
          bval = 0;
          bcode = 1;
          for (int k = 0; k < 3; k++) begin
            cand = int'(x) + s * (1 - k);
            if (cand >= 0 && cand < int'(span)) begin
              if (!have || cost_prev[cand] < bval) begin
                have = 1'b1;
                bval = cost_prev[cand];
                bcode = k;
              end
            end
          end
          cost_next[x] = e + bval;
          back_ptr[ln*span + x] = bcode[1:0];
        end
      end
      cost_prev = cost_next;
    end
    best = cost_prev[0];
    best_c = 0;
    for (int unsigned x = 1; x < span; x++) begin
      if (cost_prev[x] < best) begin
        best = cost_prev[x];
        best_c = x;
      end
    end
    c = best_c;
    for (int ln = int'(lines) - 1; ln >= 0; ln--) begin
      path[ln] = c;
      case (back_ptr[ln*span + c])
        2'd0: nc = int'(c) + s;
        2'd2: nc = int'(c) - s;
        default: nc = int'(c);
      endcase
      if (nc < 0) nc = 0;
      if (nc >= int'(span)) nc = int'(span) - 1;
      c = nc;
    end
    for (int unsigned k = 0; k < lines; k++) begin
      ent.pos = k[IdxW-1:0];
      ent.idx = path[k][IdxW-1:0];
      ent.cost = best[CostW-1:0];
      ent.last = (k + 1 == lines);
      pending_seam_q.insert(pending_seam_q.size(), ent);
    end
  endfunction

  function automatic void store_pixel(logic [PixW-1:0] px);
    if (load_cnt < StoreDepth) pix_mem[load_cnt] = px;
    load_cnt = (load_cnt + 1) & 13'h1fff;
    if (load_cnt >= clamp_dim(cfg_w) * clamp_dim(cfg_h)) begin
      load_cnt = 0;
      predict_seam();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    seam_entry_t want;
    if (rst_ni && seam_valid_o) begin
      if (pending_seam_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected seam entry pos %0d idx %0d", $time,
                 seam_position_o, seam_index_o);
      end else begin
        want = pending_seam_q.pop_front();
        if (seam_position_o !== want.pos || seam_index_o !== want.idx ||
            seam_cost_o !== want.cost || last_o !== want.last) begin
          errors++;
          $display("%0t: expected pos %0d idx %0d cost %0d last %0d, got %0d %0d %0d %0d",
                   $time, want.pos, want.idx, want.cost, want.last,
                   seam_position_o, seam_index_o, seam_cost_o, last_o);
        end
      end
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit hold);
    int unsigned gap;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    store_pixel({r, g, b});
    pixels_sent++;
    gap = pick_gap();
    if (gap > 0 || !hold) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(reg_addr_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDirection: cfg_dir = val[0];
      RegWidth:     cfg_w = val[SizeW-1:0];
      RegHeight:    cfg_h = val[SizeW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_seams();
    while (pending_seam_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_shape(logic dir, logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    drain_seams();
    write_reg(RegDirection, {31'd0, dir});
    write_reg(RegWidth, {25'd0, w});
    write_reg(RegHeight, {25'd0, h});
  endtask

  // Sends n pixels; dull frames use small values so that costs tie often.
  task automatic send_pixels(int unsigned n, bit dull);
    logic [7:0] r, g, b;
    for (int unsigned i = 0; i < n; i++) begin
      r = dull ? 8'($urandom_range(0, 2)) : 8'($urandom);
      g = dull ? 8'($urandom_range(0, 2)) : 8'($urandom);
      b = dull ? 8'($urandom_range(0, 2)) : 8'($urandom);
      send_pixel(r, g, b, i + 1 != n);
    end
  endtask

  task automatic test_tiny_frames();
    set_shape(1'b0, 7'd1, 7'd1);
    send_pixels(1, 1'b0);
    set_shape(1'b1, 7'd0, 7'd0);
    send_pixels(1, 1'b0);
    set_shape(1'b0, 7'd2, 7'd2);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b1);
    send_pixel(8'hff, 8'h00, 8'hff, 1'b0);
  endtask

  task automatic test_uniform_ties();
    set_shape(1'b0, 7'd3, 7'd3);
    for (int i = 0; i < 9; i++) send_pixel(8'h80, 8'h80, 8'h80, i != 8);
    set_shape(1'b1, 7'd3, 7'd3);
    for (int i = 0; i < 9; i++) send_pixel(8'h40, 8'h40, 8'h40, i != 8);
  endtask

  task automatic test_largest_sizes();
    set_shape(1'b1, 7'd127, 7'd1);
    send_pixels(64, 1'b0);
  endtask

  task automatic test_shrink_mid_frame();
    set_shape(1'b0, 7'd3, 7'd3);
    send_pixels(5, 1'b0);
    drain_seams();
    write_reg(RegHeight, 32'd2);
    send_pixels(1, 1'b0);
    set_shape(1'b1, 7'd3, 7'd3);
    send_pixels(7, 1'b0);
    drain_seams();
    write_reg(RegWidth, 32'd2);
    send_pixels(1, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, start_px;
    start_px = pixels_sent;
    while (pixels_sent - start_px < 12) begin
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 4);
      set_shape(1'($urandom), 7'(w), 7'(h));
      steady = ($urandom_range(0, 3) == 0);
      send_pixels(w * h, $urandom_range(0, 2) == 0);
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tiny_frames();
    test_uniform_ties();
    test_largest_sizes();
    test_shrink_mid_frame();
    test_random_frames();
    drain_seams();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_seam_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
